### rtl/core/stl_pkg.sv
// Shared types and constants for the spatio-temporal Laplacian filter.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package stl_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COORD_W    = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = $clog2(MAX_WIDTH / 2) + $clog2(MAX_HEIGHT / 2);
    localparam int PIX_W      = 24;
    localparam int NUM_BANKS  = 3;
    localparam int NUM_SUBS   = 4;
    localparam int QDEPTH     = 4;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_BIAS  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        logic               filter;
        logic               use_old;
        logic               store;
        logic               frame_end;
        logic [1:0]         bank_cur;
        logic [1:0]         bank_prev;
        logic [1:0]         bank_old;
    } t_item;

    function automatic logic [1:0] bank_next(input logic [1:0] b);
        logic [1:0] r;
        case (b)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/spatiotemporal_laplacian_filter.sv
// Spatio-temporal six-neighbour Laplacian filter, top level.
// A word goes through the queue, then the stage-one, stage-two and output registers.
// Throughput: one pixel per cycle unless the output stalls, set by dual-read store slices.
// Reset clears counters, frame rotation, queue and pipeline valids and loads
// the register defaults; the frame stores are not cleared and need no pass.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
`default_nettype none
module spatiotemporal_laplacian_filter
    import stl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_red_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_red_out,
    output logic             o_frame_end
);
    t_item      push_item;
    t_item      pop_item;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [7:0] bias;

    stl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item),
        .o_bias      (bias)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty)
    );

    stl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (pop_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_bias      (bias),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_frame_end (o_frame_end)
    );
endmodule
`default_nettype wire

### rtl/core/stl_ram.sv
// One frame store slice: one write port and two registered read ports.
// Depends on stl_pkg for address and data widths.
`default_nettype none
module stl_ram
    import stl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [PIX_W-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [PIX_W-1:0]  o_rdata_a,
    output logic      [PIX_W-1:0]  o_rdata_b
);
    logic [PIX_W-1:0] mem [2**ADDR_W];
    logic [PIX_W-1:0] r_rdata_a;
    logic [PIX_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule
`default_nettype wire

### rtl/core/stl_queue.sv
// Short queue of classified words between the front and back parts.
// Depends on stl_pkg for the word type and depth.
`default_nettype none
module stl_queue
    import stl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_empty
);
    localparam int PTR_W = $clog2(QDEPTH);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [PTR_W:0]     r_count;
    logic [PTR_W:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QDEPTH));
endmodule
`default_nettype wire

### rtl/core/stl_front.sv
// Front part: configuration registers, raster counters, frame rotation and
// classification of each incoming pixel word. Depends on stl_pkg.
`default_nettype none
module stl_front
    import stl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_red_in,
    input  wire logic        i_full,
    output logic             o_push,
    output t_item            o_item,
    output logic [7:0]       o_bias
);
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [7:0]  r_bias;
    logic [9:0]  r_col;
    logic [9:0]  r_line;
    logic [1:0]  r_bank;
    logic [1:0]  r_frames;

    logic [10:0] w;
    logic [10:0] h;
    logic [10:0] ew;
    logic [10:0] eh;
    logic        last_col;
    logic        last_line;
    logic        inner;

    always_comb begin
        w = (r_width < 11'd3) ? 11'd3 : ((r_width > 11'd1024) ? 11'd1024 : r_width);
        h = (r_height < 11'd3) ? 11'd3 : ((r_height > 11'd1024) ? 11'd1024 : r_height);
        ew = (w > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : w;
        eh = (h > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : h;
        last_col  = {1'b0, r_col} >= (w - 11'd1);
        last_line = {1'b0, r_line} >= (h - 11'd1);
        inner = (r_col != '0) && (({1'b0, r_col} + 11'd1) < ew)
             && (r_line != '0) && (({1'b0, r_line} + 11'd1) < eh);

        o_item.x         = r_col[COORD_W-1:0];
        o_item.y         = r_line[COORD_W-1:0];
        o_item.pix       = {i_red_in, i_green_in, i_blue_in};
        o_item.filter    = (r_frames != 2'd0) && inner;
        o_item.use_old   = (r_frames == 2'd2);
        o_item.store     = ({1'b0, r_col} < 11'(MAX_WIDTH))
                        && ({1'b0, r_line} < 11'(MAX_HEIGHT));
        o_item.frame_end = last_col && last_line;
        o_item.bank_cur  = r_bank;
        o_item.bank_old  = bank_next(r_bank);
        o_item.bank_prev = bank_next(bank_next(r_bank));
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign o_bias     = r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 11'd480;
            r_bias   <= 8'd127;
            r_col    <= '0;
            r_line   <= '0;
            r_bank   <= '0;
            r_frames <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    CFG_OUTPUT_BIAS:  r_bias   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (o_push) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_line) begin
                        r_line <= '0;
                        r_bank <= bank_next(r_bank);
                        if (r_frames != 2'd2) begin
                            r_frames <= r_frames + 2'd1;
                        end
                    end else begin
                        r_line <= r_line + 10'd1;
                    end
                end else begin
                    r_col <= r_col + 10'd1;
                end
            end
        end
    end

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != 2'd3) else $error("bank pointer out of range");
    a_frames_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames != 2'd3) else $error("frame count passed saturation");
    a_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_item.frame_end |=> r_col == '0 && r_line == '0)
        else $error("counters did not wrap after frame end");
endmodule
`default_nettype wire

### rtl/core/stl_back.sv
// Back part: frame store access, six-neighbour sum, clamp and output register.
// Depends on stl_pkg and stl_ram.
`default_nettype none
module stl_back
    import stl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_item      i_item,
    input  wire logic       i_empty,
    output logic            o_pop,
    input  wire logic [7:0] i_bias,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_blue_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_red_out,
    output logic            o_frame_end
);
    logic en;
    logic [ADDR_W-1:0] a_ctr, a_up, a_dn, a_lf, a_rt;
    logic [1:0] sub_c, sub_v, sub_h;
    logic [COORD_W-1:0] ym1, yp1, xm1, xp1;

    logic [PIX_W-1:0] rd_a [NUM_BANKS][NUM_SUBS];
    logic [PIX_W-1:0] rd_b [NUM_BANKS][NUM_SUBS];

    logic        r_s1_v;
    t_item       r_s1;
    logic        r_s2_v;
    logic        r_s2_filter;
    logic        r_s2_end;
    logic [PIX_W-1:0]  r_s2_pix;
    logic signed [11:0] r_s2_sum [3];
    logic signed [11:0] n_s2_sum [3];
    logic        r_out_v;
    logic [PIX_W-1:0]  r_out_pix;
    logic        r_out_end;
    logic [PIX_W-1:0]  n_out_pix;

    assign en    = !r_out_v || i_out_ready;
    assign o_pop = en && !i_empty;

    // Stores are split by row and column parity so the five neighbours
    // never need more than two reads from one slice.
    always_comb begin
        ym1 = i_item.y - 1'b1;
        yp1 = i_item.y + 1'b1;
        xm1 = i_item.x - 1'b1;
        xp1 = i_item.x + 1'b1;
        a_ctr = {i_item.y[COORD_W-1:1], i_item.x[COORD_W-1:1]};
        a_up  = {ym1[COORD_W-1:1], i_item.x[COORD_W-1:1]};
        a_dn  = {yp1[COORD_W-1:1], i_item.x[COORD_W-1:1]};
        a_lf  = {i_item.y[COORD_W-1:1], xm1[COORD_W-1:1]};
        a_rt  = {i_item.y[COORD_W-1:1], xp1[COORD_W-1:1]};
        sub_c = {i_item.y[0], i_item.x[0]};
        sub_v = {~i_item.y[0], i_item.x[0]};
        sub_h = {i_item.y[0], ~i_item.x[0]};
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        for (genvar s = 0; s < NUM_SUBS; s++) begin : g_sub
            logic              we;
            logic [ADDR_W-1:0] ra;
            logic [ADDR_W-1:0] rb;
            always_comb begin
                we = o_pop && i_item.store && (i_item.bank_cur == 2'(b))
                  && (sub_c == 2'(s));
                if (i_item.bank_prev == 2'(b)) begin
                    if (sub_c == 2'(s)) begin
                        ra = a_ctr;
                    end else if (sub_v == 2'(s)) begin
                        ra = a_up;
                    end else begin
                        ra = a_lf;
                    end
                end else begin
                    ra = a_ctr;
                end
                rb = (sub_v == 2'(s)) ? a_dn : a_rt;
            end
            stl_ram u_ram (
                .i_clk     (i_clk),
                .i_we      (we),
                .i_waddr   (a_ctr),
                .i_wdata   (i_item.pix),
                .i_re      (en),
                .i_raddr_a (ra),
                .i_raddr_b (rb),
                .o_rdata_a (rd_a[b][s]),
                .o_rdata_b (rd_b[b][s])
            );
        end
    end

    always_comb begin
        logic [1:0]  c, v, hz;
        logic [PIX_W-1:0] ctr, up, dn, lf, rt, old;
        logic [10:0] pos;
        logic [10:0] neg;
        logic [7:0]  k;
        c  = {r_s1.y[0], r_s1.x[0]};
        v  = {~r_s1.y[0], r_s1.x[0]};
        hz = {r_s1.y[0], ~r_s1.x[0]};
        ctr = rd_a[r_s1.bank_prev][c];
        up  = rd_a[r_s1.bank_prev][v];
        dn  = rd_b[r_s1.bank_prev][v];
        lf  = rd_a[r_s1.bank_prev][hz];
        rt  = rd_b[r_s1.bank_prev][hz];
        old = r_s1.use_old ? rd_a[r_s1.bank_old][c] : r_s1.pix;
        for (int i = 0; i < 3; i++) begin
            pos = 11'(r_s1.pix[8*i +: 8]) + 11'(old[8*i +: 8]) + 11'(up[8*i +: 8])
                + 11'(dn[8*i +: 8]) + 11'(lf[8*i +: 8]) + 11'(rt[8*i +: 8])
                + 11'(i_bias);
            k   = ctr[8*i +: 8];
            neg = {1'b0, k, 2'b00} + {2'b00, k, 1'b0};
            n_s2_sum[i] = $signed({1'b0, pos}) - $signed({1'b0, neg});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_s2_filter) begin
                n_out_pix[8*i +: 8] = r_s2_pix[8*i +: 8];
            end else if (r_s2_sum[i][11]) begin
                n_out_pix[8*i +: 8] = 8'd0;
            end else if (r_s2_sum[i][10:8] != 3'd0) begin
                n_out_pix[8*i +: 8] = 8'd255;
            end else begin
                n_out_pix[8*i +: 8] = r_s2_sum[i][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= o_pop;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1        <= i_item;
            r_s2_filter <= r_s1.filter;
            r_s2_end    <= r_s1.frame_end;
            r_s2_pix    <= r_s1.pix;
            r_s2_sum    <= n_s2_sum;
            r_out_pix   <= n_out_pix;
            r_out_end   <= r_s2_end;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_blue_out  = r_out_pix[7:0];
    assign o_green_out = r_out_pix[15:8];
    assign o_red_out   = r_out_pix[23:16];
    assign o_frame_end = r_out_end;
endmodule
`default_nettype wire

### tb/spatiotemporal_laplacian_filter_test.sv
// Self-checking testbench for the spatio-temporal Laplacian filter.
// Depends on stl_pkg and the spatiotemporal_laplacian_filter top level.
// A local copy of the frame stores predicts every output word.
`default_nettype none
module spatiotemporal_laplacian_filter_test;
    import stl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int BANK_SIZE   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 100_000;

    typedef enum int { PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_MIXED } t_pattern;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_blue_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_red_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_red_out;
    logic        o_frame_end;

    spatiotemporal_laplacian_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_frame_end (o_frame_end)
    );

    // Filter state mirrored from the block.
    logic [23:0] frame_mem [0:3*BANK_SIZE-1];
    int unsigned cur_bank, col_pos, line_pos, frames_done;
    int unsigned width_reg = 640, height_reg = 480, bias_reg = 127;

    t_pixel expected_pixels[$];
    int     errors = 0;
    int     cycles = 0;
    bit     in_idle_en = 1'b0;
    bit     out_idle_en = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned size_limit(input int unsigned v);
        if (v < 3) return 3;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic int unsigned mem_addr(input int unsigned bank, x, y);
        return bank * BANK_SIZE + y * MAX_WIDTH + x;
    endfunction

    task automatic predict_filtered_pixel(input logic [23:0] cur);
        int unsigned w, h, ew, eh, x, y, pb, ob;
        logic [23:0] ctr, up, dn, lf, rt, old, res;
        int v;
        bit last_col, last_line;
        t_pixel p;
        w = size_limit(width_reg);
        h = size_limit(height_reg);
        ew = (w < MAX_WIDTH) ? w : MAX_WIDTH;
        eh = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
        x = col_pos;
        y = line_pos;
        res = cur;
        last_col = (x >= w - 1);
        last_line = (y >= h - 1);
        if (frames_done >= 1 && x >= 1 && x + 1 < ew && y >= 1 && y + 1 < eh) begin
            pb = (cur_bank + 2) % 3;
            ob = (cur_bank + 1) % 3;
            ctr = frame_mem[mem_addr(pb, x, y)];
            up  = frame_mem[mem_addr(pb, x, y - 1)];
            dn  = frame_mem[mem_addr(pb, x, y + 1)];
            lf  = frame_mem[mem_addr(pb, x - 1, y)];
            rt  = frame_mem[mem_addr(pb, x + 1, y)];
            old = (frames_done >= 2) ? frame_mem[mem_addr(ob, x, y)] : cur;
            for (int c = 0; c < 3; c++) begin
                v = int'(cur[8*c +: 8]) + int'(old[8*c +: 8]) + int'(up[8*c +: 8])
                  + int'(dn[8*c +: 8]) + int'(lf[8*c +: 8]) + int'(rt[8*c +: 8])
                  - 6 * int'(ctr[8*c +: 8]) + int'(bias_reg);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                res[8*c +: 8] = v[7:0];
            end
        end
        if (x < MAX_WIDTH && y < MAX_HEIGHT) frame_mem[mem_addr(cur_bank, x, y)] = cur;
        p.blue = res[7:0];
        p.green = res[15:8];
        p.red = res[23:16];
        p.frame_end = last_col && last_line;
        expected_pixels.push_back(p);
        if (last_col) begin
            col_pos = 0;
            if (last_line) begin
                line_pos = 0;
                cur_bank = (cur_bank + 1) % 3;
                if (frames_done < 2) frames_done++;
            end else begin
                line_pos = (y + 1) & 10'h3FF;
            end
        end else begin
            col_pos = (x + 1) & 10'h3FF;
        end
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Called on a clock edge; returns after the edge where the write lands.
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) width_reg = data;
        else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
        else if (idx == CFG_OUTPUT_BIAS) bias_reg = data[7:0];
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [23:0] pix);
        while (in_idle_en && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue_in <= pix[7:0];
        i_green_in <= pix[15:8];
        i_red_in <= pix[23:16];
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_filtered_pixel(pix);
    endtask

    function automatic logic [7:0] pick_channel(input t_pattern pat);
        case (pat)
            PAT_ZERO: return 8'h00;
            PAT_FULL: return 8'hFF;
            PAT_MIXED: begin
                if ($urandom_range(1)) return $urandom_range(1) ? 8'hFF : 8'h00;
                return 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_words(input int total, input t_pattern pat);
        for (int i = 0; i < total; i++) begin
            send_word({pick_channel(pat), pick_channel(pat), pick_channel(pat)});
            // Now and then hold the sender back until the pipeline empties.
            if (in_idle_en && $urandom_range(299) == 0) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
        end
    endtask

    task automatic send_frames(input int count, input t_pattern pat);
        int total;
        total = count * size_limit(width_reg) * size_limit(height_reg);
        send_words(total, pat);
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [10:0] bias);
        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_OUTPUT_BIAS, bias);
    endtask

    // Frame sizes never grow after the first frame, so every store entry
    // that a filtered pixel reads has been written. The first line is wider
    // than the store; its columns past the store must not be kept.
    task automatic test_store_limits();
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        set_frame(11'd514, 11'd16, 11'd127);
        send_words(514, PAT_MIXED);
        set_frame(11'd16, 11'd12, 11'd200);
        send_words(11 * 16, PAT_RANDOM);
        send_frames(4, PAT_RANDOM);
    endtask

    task automatic test_random_sizes();
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        set_frame(11'd12, 11'd9, 11'h700);
        send_frames(3, PAT_MIXED);
        set_frame(11'd7, 11'd5, 11'($urandom));
        send_frames(3, PAT_RANDOM);
    endtask

    task automatic test_extreme_pixels();
        set_frame(11'd3, 11'd3, 11'd0);
        write_reg(CFG_UNUSED, 11'h7FF);
        send_frames(1, PAT_ZERO);
        set_frame(11'd3, 11'd3, 11'd255);
        send_frames(1, PAT_FULL);
    endtask

    // Sizes below the lower limit act as the smallest frame.
    task automatic test_small_sizes();
        set_frame(11'd2, 11'd0, 11'd50);
        send_frames(2, PAT_RANDOM);
        set_frame(11'd3, 11'd3, 11'h700);
        send_frames(4, PAT_MIXED);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !out_idle_en || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected word b=%h g=%h r=%h end=%b", $time,
                         o_blue_out, o_green_out, o_red_out, o_frame_end);
                errors++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (o_blue_out !== exp_px.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, exp_px.blue,
                             o_blue_out);
                    errors++;
                end
                if (o_green_out !== exp_px.green) begin
                    $display("%0t: green expected %h actual %h", $time, exp_px.green,
                             o_green_out);
                    errors++;
                end
                if (o_red_out !== exp_px.red) begin
                    $display("%0t: red expected %h actual %h", $time, exp_px.red,
                             o_red_out);
                    errors++;
                end
                if (o_frame_end !== exp_px.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             exp_px.frame_end, o_frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("spatiotemporal_laplacian_filter_test NOT OK");
            $finish;
        end
    end

    initial begin
        cur_bank = 0;
        col_pos = 0;
        line_pos = 0;
        frames_done = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_limits();
        test_random_sizes();
        test_extreme_pixels();
        test_small_sizes();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("spatiotemporal_laplacian_filter_test OK");
        end else begin
            $display("spatiotemporal_laplacian_filter_test NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/core/stl_pkg.sv
rtl/core/stl_ram.sv
rtl/core/stl_queue.sv
rtl/core/stl_front.sv
rtl/core/stl_back.sv
rtl/core/spatiotemporal_laplacian_filter.sv
tb/spatiotemporal_laplacian_filter_test.sv
